>>> rtl/lidar_sector_min_distance_macros.svh
// ============================================================================
// Assertion macros for the lidar sector minimum-distance block
// Concurrent assertion helpers; defining ASSERT_OFF compiles them away.
// ============================================================================
`ifndef LIDAR_SECTOR_MIN_DISTANCE_MACROS_SVH
`define LIDAR_SECTOR_MIN_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every rising edge outside reset.
`define LSMD_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);
// The expression must never be true at a rising edge outside reset.
`define LSMD_ASSERT_NEVER(label, clk_sig, rst_sig, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
        else $error(msg);
`else
`define LSMD_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define LSMD_ASSERT_NEVER(label, clk_sig, rst_sig, expr, msg)
`endif
`endif

>>> rtl/lsmd_pkg.sv
// ============================================================================
// Lidar sector minimum-distance package
// Shared widths, constants, codes and structures of the sector histogram.
// ============================================================================
`default_nettype none

package lsmd_pkg;

    localparam int DEFAULT_MAX_SECTORS = 64;

    localparam int ANGLE_W     = 16;
    localparam int NORM_W      = 15;
    localparam int DIST_W      = 20;
    localparam int COUNT_REG_W = 7;
    localparam int THR_W       = 20;
    localparam int OUT_IDX_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;

    // Full circle in Q4.12 radians.
    localparam int TWO_PI_Q12 = 25736;

    localparam logic [DIST_W-1:0]      EMPTY_DISTANCE = 20'd999000;
    localparam logic [DIST_W-1:0]      MIN_VALID_MM   = 20'd10;
    localparam logic [COUNT_REG_W-1:0] COUNT_RESET    = 7'd8;
    localparam logic [THR_W-1:0]       THR_RESET      = 20'd500;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTOR_COUNT    = 1'b0,
        CFG_BLOCK_THRESHOLD = 1'b1
    } cfg_index_t;

    // A sample travelling down the row of cells.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dist_mm;
    } token_t;

    // Readout control broadcast to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lsmd_in_if.sv
// ============================================================================
// Sample channel
// Valid/ready channel carrying samples and finish commands.
// ============================================================================
`default_nettype none

interface lsmd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [lsmd_pkg::ANGLE_W-1:0] angle_rad;
    logic [lsmd_pkg::DIST_W-1:0]         distance_mm;

    modport source (output valid, output operation, output angle_rad,
                    output distance_mm, input ready);
    modport sink (input valid, input operation, input angle_rad,
                  input distance_mm, output ready);
endinterface

`default_nettype wire

>>> rtl/lsmd_out_if.sv
// ============================================================================
// Result channel
// Valid/ready channel carrying one sector result per transaction.
// ============================================================================
`default_nettype none

interface lsmd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lsmd_pkg::OUT_IDX_W-1:0] sector_index;
    logic [lsmd_pkg::DIST_W-1:0]    min_distance;
    logic                           blocked;
    logic                           last_sector;

    modport source (output valid, output sector_index, output min_distance,
                    output blocked, output last_sector, input ready);
    modport sink (input valid, input sector_index, input min_distance,
                  input blocked, input last_sector, output ready);
endinterface

`default_nettype wire

>>> rtl/lsmd_cell.sv
// ============================================================================
// Sector cell
// Holds one sector minimum, passes samples on and shifts minima out on readout.
// ============================================================================
`default_nettype none

module lsmd_cell #(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire lsmd_pkg::token_t            tok_in,
    input  wire [IDX_W-1:0]                  idx_in,
    output lsmd_pkg::token_t                 tok_out,
    output logic [IDX_W-1:0]                 idx_out,
    input  wire lsmd_pkg::cell_ctrl_t        ctrl,
    input  wire [lsmd_pkg::DIST_W-1:0]       min_in,
    output logic [lsmd_pkg::DIST_W-1:0]      min_out
);

    logic                          hit;
    logic [lsmd_pkg::DIST_W-1:0]   min_reg;
    logic [lsmd_pkg::DIST_W-1:0]   min_next;
    logic                          tok_valid_reg;
    logic [lsmd_pkg::DIST_W-1:0]   tok_dist_reg;
    logic [IDX_W-1:0]              idx_reg;

    assign hit = tok_in.valid && (idx_in == IDX_W'(CELL_INDEX));

    always_comb
    begin
        min_next = min_reg;
        priority if (ctrl.clear)
        begin
            min_next = lsmd_pkg::EMPTY_DISTANCE;
        end
        else if (ctrl.shift)
        begin
            min_next = min_in;
        end
        else if (hit && (tok_in.dist_mm < min_reg))
        begin
            min_next = tok_in.dist_mm;
        end
        else
        begin
            min_next = min_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= lsmd_pkg::EMPTY_DISTANCE;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg       <= min_next;
            // A sample stops at the cell of its sector.
            tok_valid_reg <= tok_in.valid && !hit;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_dist_reg <= tok_in.dist_mm;
        idx_reg      <= idx_in;
    end

    assign tok_out.valid   = tok_valid_reg;
    assign tok_out.dist_mm = tok_dist_reg;
    assign idx_out         = idx_reg;
    assign min_out         = min_reg;

endmodule

`default_nettype wire

>>> rtl/lidar_sector_min_distance.sv
// ============================================================================
// Lidar sector minimum-distance histogram
// Keeps the smallest valid distance of each angular sector and reports all.
// ============================================================================
// A sample transaction is taken every cycle while the block is idle. Its
// angle is folded into one turn and multiplied by the sector count in the
// first stage, divided by the full turn through a reciprocal multiply in the
// second, and the sample then walks down a row of MAX_SECTORS cells, one cell
// per cycle, until it reaches the cell of its sector, where the minimum is
// updated. A finish transaction first waits for samples still in the stages
// and the row to land, then the minima shift out of cell 0 as one result
// transaction per sector, one per cycle when the sink is ready, and all
// cells return to 999000 mm with the last result. No sample is taken from
// the finish transaction until the last result is delivered.
// The minima live in cell flip-flops that reset clears at once.
`default_nettype none

module lidar_sector_min_distance #(
    parameter int MAX_SECTORS = lsmd_pkg::DEFAULT_MAX_SECTORS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [lsmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [lsmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    lsmd_in_if.sink                            sample_ch,
    lsmd_out_if.source                         result_ch
);

`include "lidar_sector_min_distance_macros.svh"

    localparam int IDX_W     = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_W     = $clog2(MAX_SECTORS + 1);
    localparam int NORM_W    = lsmd_pkg::NORM_W;
    localparam int DIST_W    = lsmd_pkg::DIST_W;
    localparam int OUT_IDX_W = lsmd_pkg::OUT_IDX_W;
    localparam int CREG_W    = lsmd_pkg::COUNT_REG_W;
    localparam int THR_W     = lsmd_pkg::THR_W;
    localparam int TWO_PI    = lsmd_pkg::TWO_PI_Q12;
    localparam int P_W       = NORM_W + CNT_W;
    // The product stays below 2^P_W and the divisor below 2^15, so this
    // shift makes the rounded-up reciprocal exact.
    localparam int RSHIFT    = P_W + 15;
    localparam int RECIP_W   = RSHIFT - 14;
    localparam int QP_W      = P_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RSHIFT) + 64'(TWO_PI) - 64'd1) / 64'(TWO_PI);
    localparam logic signed [NORM_W+1:0] TWO_PI_S = (NORM_W + 2)'(TWO_PI);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DRAIN = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    // Configuration.
    logic [CREG_W-1:0] count_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  act_count;

    // Controller.
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  fin_count_reg;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [CNT_W-1:0]  emit_cnt_next;
    logic              in_xact;
    logic              out_xact;
    logic              last;
    logic              busy;

    // Sector index pipeline.
    logic signed [NORM_W+1:0] a_ext;
    logic signed [NORM_W+1:0] a_1;
    logic signed [NORM_W+1:0] a_2;
    logic signed [NORM_W+1:0] a_3;
    logic [P_W-1:0]           prod_next;
    logic                     s1_valid_reg;
    logic [P_W-1:0]           s1_prod_reg;
    logic [DIST_W-1:0]        s1_dist_reg;
    logic [CNT_W-1:0]         s1_cnt_reg;
    logic [QP_W-1:0]          qprod;
    logic [CNT_W-1:0]         q_raw;
    logic [CNT_W-1:0]         q_clamp;
    logic                     s2_valid_reg;
    logic [DIST_W-1:0]        s2_dist_reg;
    logic [IDX_W-1:0]         s2_idx_reg;

    // Cell row.
    lsmd_pkg::token_t         tok_chain [0:MAX_SECTORS];
    logic [IDX_W-1:0]         idx_chain [0:MAX_SECTORS];
    logic [DIST_W-1:0]        min_chain [0:MAX_SECTORS];
    lsmd_pkg::cell_ctrl_t     cell_ctrl;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= lsmd_pkg::COUNT_RESET;
            thr_reg   <= lsmd_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lsmd_pkg::cfg_index_t'(cfg_index))
                lsmd_pkg::CFG_SECTOR_COUNT:    count_reg <= cfg_data[CREG_W-1:0];
                lsmd_pkg::CFG_BLOCK_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                default:                       thr_reg   <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            act_count = CNT_W'(1);
        end
        else if (32'(count_reg) > MAX_SECTORS)
        begin
            act_count = CNT_W'(MAX_SECTORS);
        end
        else
        begin
            act_count = CNT_W'(count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign sample_ch.ready = (state_reg == S_IDLE);
    assign in_xact         = sample_ch.valid && sample_ch.ready;
    assign result_ch.valid = (state_reg == S_EMIT);
    assign out_xact        = result_ch.valid && result_ch.ready;
    assign last            = (emit_cnt_reg == (fin_count_reg - CNT_W'(1)));

    // ------------------------------------------------------------------
    // Stage 1: fold the angle into one turn and scale by the sector count
    // ------------------------------------------------------------------
    always_comb
    begin
        a_ext = (NORM_W + 2)'(sample_ch.angle_rad);
        a_1   = (a_ext < 0) ? (a_ext + TWO_PI_S) : a_ext;
        // The most negative angles need a second turn added.
        a_2   = (a_1 < 0) ? (a_1 + TWO_PI_S) : a_1;
        a_3   = (a_2 >= TWO_PI_S) ? (a_2 - TWO_PI_S) : a_2;
        prod_next = P_W'(a_3[NORM_W-1:0]) * P_W'(act_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xact && (sample_ch.operation == lsmd_pkg::OP_SAMPLE)
                            && (sample_ch.distance_mm > lsmd_pkg::MIN_VALID_MM);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= prod_next;
        s1_dist_reg <= sample_ch.distance_mm;
        s1_cnt_reg  <= act_count;
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by the full turn through the reciprocal
    // ------------------------------------------------------------------
    always_comb
    begin
        qprod   = QP_W'(s1_prod_reg) * QP_W'(RECIP);
        q_raw   = qprod[RSHIFT +: CNT_W];
        q_clamp = (q_raw >= s1_cnt_reg) ? (s1_cnt_reg - CNT_W'(1)) : q_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dist_reg <= s1_dist_reg;
        s2_idx_reg  <= q_clamp[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Row of sector cells
    // ------------------------------------------------------------------
    assign tok_chain[0].valid     = s2_valid_reg;
    assign tok_chain[0].dist_mm   = s2_dist_reg;
    assign idx_chain[0]           = s2_idx_reg;
    assign min_chain[MAX_SECTORS] = lsmd_pkg::EMPTY_DISTANCE;

    assign cell_ctrl.shift = out_xact && !last;
    assign cell_ctrl.clear = out_xact && last;

    for (genvar k = 0; k < MAX_SECTORS; k++)
    begin : g_cell
        lsmd_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[k]),
            .idx_in  (idx_chain[k]),
            .tok_out (tok_chain[k+1]),
            .idx_out (idx_chain[k+1]),
            .ctrl    (cell_ctrl),
            .min_in  (min_chain[k+1]),
            .min_out (min_chain[k])
        );
    end

    always_comb
    begin
        busy = s1_valid_reg;
        for (int i = 0; i <= MAX_SECTORS; i++)
        begin
            busy = busy | tok_chain[i].valid;
        end
    end

    // ------------------------------------------------------------------
    // Finish sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        emit_cnt_next = emit_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xact && (sample_ch.operation == lsmd_pkg::OP_FINISH))
                begin
                    state_next    = S_DRAIN;
                    emit_cnt_next = '0;
                end
            end
            S_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_xact)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_cnt_next = emit_cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_cnt_reg  <= '0;
            fin_count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            emit_cnt_reg <= emit_cnt_next;
            if (in_xact && (sample_ch.operation == lsmd_pkg::OP_FINISH))
            begin
                fin_count_reg <= act_count;
            end
        end
    end

    assign result_ch.sector_index = OUT_IDX_W'(emit_cnt_reg);
    assign result_ch.min_distance = min_chain[0];
    assign result_ch.blocked      = (min_chain[0] < thr_reg);
    assign result_ch.last_sector  = last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSMD_ASSERT_NEVER(a_emit_drained, clk, rst_n, result_ch.valid && busy,
        "sector result offered while samples are still in the cell row")
    `LSMD_ASSERT_NEVER(a_no_overlap, clk, rst_n, sample_ch.ready && result_ch.valid,
        "sample channel ready while a frame is being reported")
    `LSMD_ASSERT_NEVER(a_index_range, clk, rst_n,
        result_ch.valid && (emit_cnt_reg >= fin_count_reg),
        "reported sector index is not below the sector count")
    `LSMD_ASSERT(a_last_ends_frame, clk, rst_n,
        out_xact && last |=> (state_reg == S_IDLE)
            && (min_chain[0] == lsmd_pkg::EMPTY_DISTANCE),
        "last sector result did not clear the store and return to idle")

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the lidar sector minimum-distance histogram
// Sample and finish transactions go to the block from a directed table and
// then from random frames. Register settings change between frames. A model
// in this file predicts the sector results of every finish. Each result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int ANGLE_W     = lsmd_pkg::ANGLE_W;
    localparam int DIST_W      = lsmd_pkg::DIST_W;
    localparam int OUT_IDX_W   = lsmd_pkg::OUT_IDX_W;
    localparam int CFG_IDX_W   = lsmd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = lsmd_pkg::CFG_DATA_W;
    localparam int COUNT_REG_W = lsmd_pkg::COUNT_REG_W;
    localparam int THR_W       = lsmd_pkg::THR_W;
    localparam int TWO_PI_Q12  = lsmd_pkg::TWO_PI_Q12;
    localparam logic [DIST_W-1:0]      MIN_VALID_MM   = lsmd_pkg::MIN_VALID_MM;
    localparam logic [DIST_W-1:0]      EMPTY_DISTANCE = lsmd_pkg::EMPTY_DISTANCE;
    localparam logic [COUNT_REG_W-1:0] COUNT_RESET    = lsmd_pkg::COUNT_RESET;
    localparam logic [THR_W-1:0]       THR_RESET      = lsmd_pkg::THR_RESET;

    localparam int SECTOR_SLOTS  = lsmd_pkg::DEFAULT_MAX_SECTORS;
    // Samples can still be walking the cell row after the last result.
    localparam int SETTLE_CYCLES = 2 * SECTOR_SLOTS + 8;
    localparam int RANDOM_ITEMS  = 140;
    localparam int MAX_DIST      = (1 << DIST_W) - 1;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] sector_index;
        logic [DIST_W-1:0]    min_distance;
        logic                 blocked;
        logic                 last_sector;
    } sector_report_t;

    // One step of the directed table: a register write or a transaction.
    // A finish may carry the value that every sector must report.
    typedef struct packed {
        logic                      is_cfg;
        lsmd_pkg::cfg_index_t      reg_sel;
        logic [CFG_DATA_W-1:0]     reg_val;
        logic                      op;
        logic signed [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]         dist_mm;
        logic                      known;
        logic [DIST_W-1:0]         known_min;
        logic                      known_blk;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsmd_in_if  sample_if ();
    lsmd_out_if result_if ();

    lidar_sector_min_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_if),
        .result_ch (result_if)
    );

    // Shadow copy of the block state and its registers.
    logic [DIST_W-1:0]      sector_min [SECTOR_SLOTS];
    logic [COUNT_REG_W-1:0] cur_count;
    logic [THR_W-1:0]       cur_threshold;

    sector_report_t pending_reports[$];
    int             mismatch_count = 0;
    int             burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic plan_row_t row_sample(input int ang, input int unsigned dist_mm);
        plan_row_t r;
        r = '0;
        r.op = lsmd_pkg::OP_SAMPLE;
        r.angle = ang[ANGLE_W-1:0];
        r.dist_mm = dist_mm[DIST_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t row_finish(input bit known, input int unsigned known_min,
                                             input bit known_blk);
        plan_row_t r;
        r = '0;
        r.op = lsmd_pkg::OP_FINISH;
        r.known = known;
        r.known_min = known_min[DIST_W-1:0];
        r.known_blk = known_blk;
        return r;
    endfunction

    function automatic plan_row_t row_cfg(input lsmd_pkg::cfg_index_t sel,
                                          input int unsigned val);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val[CFG_DATA_W-1:0];
        return r;
    endfunction

    function automatic int active_sectors();
        if (cur_count == 0)
            return 1;
        if (cur_count > SECTOR_SLOTS)
            return SECTOR_SLOTS;
        return int'(cur_count);
    endfunction

    // Updates the shadow minima for a sample, or queues the reports of a finish.
    task automatic update_sector_model(input logic op, input logic signed [ANGLE_W-1:0] ang,
                                       input logic [DIST_W-1:0] dist_mm, input logic known,
                                       input logic [DIST_W-1:0] known_min,
                                       input logic known_blk);
        int n;
        int a;
        int sec;
        sector_report_t r;
        n = active_sectors();
        if (op == lsmd_pkg::OP_SAMPLE)
        begin
            a = ang;
            if (a < 0)
                a += TWO_PI_Q12;
            if (a < 0)
                a += TWO_PI_Q12;
            if (a >= TWO_PI_Q12)
                a -= TWO_PI_Q12;
            sec = (a * n) / TWO_PI_Q12;
            if (sec >= n)
                sec = n - 1;
            if (dist_mm > MIN_VALID_MM && dist_mm < sector_min[sec])
                sector_min[sec] = dist_mm;
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                r.sector_index = k[OUT_IDX_W-1:0];
                r.min_distance = known ? known_min : sector_min[k];
                r.blocked      = known ? known_blk : (sector_min[k] < cur_threshold);
                r.last_sector  = (k == n - 1);
                pending_reports.push_back(r);
            end
            foreach (sector_min[i])
                sector_min[i] = EMPTY_DISTANCE;
        end
    endtask

    // Entered and left at a falling edge; valid stays high into the next call.
    task automatic send_transaction(input logic op, input logic signed [ANGLE_W-1:0] ang,
                                    input logic [DIST_W-1:0] dist_mm, input logic known,
                                    input logic [DIST_W-1:0] known_min,
                                    input logic known_blk);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                sample_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        sample_if.valid       = 1'b1;
        sample_if.operation   = op;
        sample_if.angle_rad   = ang;
        sample_if.distance_mm = dist_mm;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        update_sector_model(op, ang, dist_mm, known, known_min, known_blk);
        @(negedge clk);
    endtask

    task automatic write_register(input lsmd_pkg::cfg_index_t sel,
                                  input logic [CFG_DATA_W-1:0] val);
        sample_if.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == lsmd_pkg::CFG_SECTOR_COUNT)
            cur_count = val[COUNT_REG_W-1:0];
        else
            cur_threshold = val[THR_W-1:0];
        burst_left = 0;
    endtask

    // Result receiver: moves at random between three stall patterns.
    initial
    begin
        int mode;
        int stretch;
        result_if.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(8, 60);
            for (int i = 0; i < stretch; i++)
            begin
                @(negedge clk);
                case (mode)
                    0: result_if.ready = 1'b1;
                    1: result_if.ready = 1'($urandom_range(0, 1));
                    default: result_if.ready = (i % 4 == 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        sector_report_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result for sector %0d arrived with none expected",
                       result_if.sector_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result_if.sector_index !== want.sector_index)
                begin
                    $error("sector_index: expected %0d, got %0d",
                           want.sector_index, result_if.sector_index);
                    mismatch_count++;
                end
                if (result_if.min_distance !== want.min_distance)
                begin
                    $error("min_distance: expected %0d, got %0d",
                           want.min_distance, result_if.min_distance);
                    mismatch_count++;
                end
                if (result_if.blocked !== want.blocked)
                begin
                    $error("blocked: expected %0b, got %0b", want.blocked, result_if.blocked);
                    mismatch_count++;
                end
                if (result_if.last_sector !== want.last_sector)
                begin
                    $error("last_sector: expected %0b, got %0b",
                           want.last_sector, result_if.last_sector);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        plan_row_t plan[$];
        int random_items;
        int n_samples;
        int n;
        int a;
        int d;
        int pick;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = lsmd_pkg::CFG_SECTOR_COUNT;
        cfg_data              = '0;
        sample_if.valid       = 1'b0;
        sample_if.operation   = lsmd_pkg::OP_SAMPLE;
        sample_if.angle_rad   = '0;
        sample_if.distance_mm = '0;
        cur_count             = COUNT_RESET;
        cur_threshold         = THR_RESET;
        foreach (sector_min[i])
            sector_min[i] = EMPTY_DISTANCE;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        plan = '{
            // Eight empty sectors right after reset.
            row_finish(1, 999000, 0),
            row_sample(0, 11),
            row_sample(0, 10),
            row_sample(25735, 600),
            row_sample(-1, 499),
            row_sample(-32768, 0),
            row_sample(32767, 12345),
            row_sample(25736, 500),
            row_sample(-25736, 777),
            row_sample(12868, 1048575),
            row_finish(0, 0, 0),
            // The previous finish cleared the store.
            row_finish(1, 999000, 0),
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 64),
            row_sample(25735, 20),
            row_sample(402, 30),
            row_sample(403, 31),
            row_finish(0, 0, 0),
            row_cfg(lsmd_pkg::CFG_BLOCK_THRESHOLD, 0),
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 1),
            row_sample(5000, 11),
            row_finish(0, 0, 0),
            row_cfg(lsmd_pkg::CFG_BLOCK_THRESHOLD, 1048575),
            row_finish(1, 999000, 1),
            // A count of zero acts as a single sector.
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 0),
            row_sample(-100, 50),
            row_finish(0, 0, 0),
            // A count above the cell row acts as the full row.
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 127),
            row_finish(1, 999000, 1),
            row_sample(100, 40),
            row_sample(-4000, 45),
            // Count changes in the middle of a frame keep the minima.
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 3),
            row_sample(20000, 60),
            row_finish(0, 0, 0),
            row_cfg(lsmd_pkg::CFG_BLOCK_THRESHOLD, 500),
            row_cfg(lsmd_pkg::CFG_SECTOR_COUNT, 8)
        };
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_register(plan[i].reg_sel, plan[i].reg_val);
            else
                send_transaction(plan[i].op, plan[i].angle, plan[i].dist_mm, plan[i].known,
                                 plan[i].known_min, plan[i].known_blk);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    n = $urandom_range(1, 12);
                else if (pick < 8)
                    n = $urandom_range(13, 64);
                else
                    n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                    : $urandom_range(64, 127);
                write_register(lsmd_pkg::CFG_SECTOR_COUNT, CFG_DATA_W'(n));
            end
            if ($urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    d = $urandom_range(0, 3000);
                else if (pick < 8)
                    d = $urandom_range(0, MAX_DIST);
                else
                    case ($urandom_range(0, 3))
                        0: d = 0;
                        1: d = MAX_DIST;
                        2: d = 999000;
                        default: d = 999001;
                    endcase
                write_register(lsmd_pkg::CFG_BLOCK_THRESHOLD, CFG_DATA_W'(d));
            end
            n = active_sectors();
            n_samples = $urandom_range(2, 20);
            for (int s = 0; s < n_samples; s++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    a = $urandom_range(0, 65535) - 32768;
                else if (pick < 8)
                begin
                    // Land on or next to a sector boundary, sometimes one turn off.
                    a = ($urandom_range(0, n - 1) * TWO_PI_Q12) / n
                        + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 2) == 0)
                        a -= TWO_PI_Q12;
                    else if ($urandom_range(0, 2) == 0 && a + TWO_PI_Q12 <= 32767)
                        a += TWO_PI_Q12;
                end
                else
                    case ($urandom_range(0, 7))
                        0: a = -32768;
                        1: a = 32767;
                        2: a = 0;
                        3: a = -1;
                        4: a = TWO_PI_Q12 - 1;
                        5: a = TWO_PI_Q12;
                        6: a = -TWO_PI_Q12;
                        default: a = -TWO_PI_Q12 - 1;
                    endcase
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    d = $urandom_range(0, 12);
                else if (pick == 1)
                begin
                    d = int'(cur_threshold) + $urandom_range(0, 4) - 2;
                    if (d < 0)
                        d = 0;
                    if (d > MAX_DIST)
                        d = MAX_DIST;
                end
                else if (pick == 2)
                    d = $urandom_range(11, 3000);
                else
                    d = $urandom_range(0, MAX_DIST);
                send_transaction(lsmd_pkg::OP_SAMPLE, a[ANGLE_W-1:0], d[DIST_W-1:0],
                                 1'b0, '0, 1'b0);
                random_items++;
            end
            // Most frames end with a finish; the rest run on into the next setting.
            if ($urandom_range(0, 4) != 0)
            begin
                send_transaction(lsmd_pkg::OP_FINISH, ANGLE_W'($urandom_range(0, 65535)),
                                 DIST_W'($urandom_range(0, MAX_DIST)), 1'b0, '0, 1'b0);
                random_items++;
            end
        end
        send_transaction(lsmd_pkg::OP_FINISH, '0, '0, 1'b0, '0, 1'b0);
        sample_if.valid = 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
